### rtl/gamepad_deadzone_normalizer_unit_macros.svh
// assertion macros for the gamepad dead-zone normalizer
// used by the top level only; expects clk_i and rst_ni in scope

`ifndef GAMEPAD_DEADZONE_NORMALIZER_UNIT_MACROS_SVH
`define GAMEPAD_DEADZONE_NORMALIZER_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define GDN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define GDN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gdn_pkg.sv
// shared types, constants and helpers of the gamepad dead-zone normalizer
// no dependencies; used by the interfaces, the lane and the top level
`timescale 1ns / 1ps

package gdn_pkg;

  // controller slots that count as real pads
  localparam int unsigned PAD_COUNT = 4;

  // full-scale values and dead-zone limits
  localparam logic [14:0] STICK_FULL   = 15'h7FFF;
  localparam logic [7:0]  TRIG_FULL    = 8'hFF;
  localparam logic [14:0] STICK_DZ_MAX = STICK_FULL - 15'd1;
  localparam logic [7:0]  TRIG_DZ_MAX  = TRIG_FULL - 8'd1;

  // dead-zone reset values
  localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;
  localparam logic [7:0]  TRIG_DZ_RST  = 8'd30;

  // pipeline layout: input reg, magnitude, offset, numerator, divider steps, sign
  localparam int unsigned DIV_STEPS  = 15;
  localparam int unsigned DIV_FIRST  = 4;
  localparam int unsigned DIV_LAST   = DIV_FIRST + DIV_STEPS - 1;
  localparam int unsigned LAST_STAGE = DIV_LAST + 1;
  localparam int unsigned NUM_STAGES = LAST_STAGE + 1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_STICK  = 2'd0,
    CFG_RIGHT_STICK = 2'd1,
    CFG_TRIGGER     = 2'd2
  } gdn_cfg_idx_e;

  typedef struct packed {
    logic [1:0]         pad_number;
    logic               present;
    logic signed [15:0] left_x_raw;
    logic signed [15:0] left_y_raw;
    logic signed [15:0] right_x_raw;
    logic signed [15:0] right_y_raw;
    logic [7:0]         left_trigger_raw;
    logic [7:0]         right_trigger_raw;
    logic [15:0]        button_bits;
  } gdn_in_t;

  typedef struct packed {
    logic [1:0]         pad_out;
    logic               present_out;
    logic signed [15:0] left_x_norm;
    logic signed [15:0] left_y_norm;
    logic signed [15:0] right_x_norm;
    logic signed [15:0] right_y_norm;
    logic [14:0]        left_trigger_norm;
    logic [14:0]        right_trigger_norm;
    logic [15:0]        buttons_out;
  } gdn_out_t;

  // dead zone and the matching divisor (full scale minus dead zone)
  typedef struct packed {
    logic [14:0] dz;
    logic [14:0] den;
  } gdn_dz_t;

  // fields that ride along the pipeline next to the lanes
  typedef struct packed {
    logic [1:0]  pad;
    logic        live;
    logic [15:0] buttons;
  } gdn_sb_t;

  function automatic logic [14:0] stick_dz_clamp(logic [14:0] v);
    return (v > STICK_DZ_MAX) ? STICK_DZ_MAX : v;
  endfunction

  function automatic logic [7:0] trig_dz_clamp(logic [7:0] v);
    return (v > TRIG_DZ_MAX) ? TRIG_DZ_MAX : v;
  endfunction

endpackage

### rtl/gdn_in_if.sv
// report input channel: valid/ready plus one controller report
// depends on gdn_pkg
`timescale 1ns / 1ps

interface gdn_in_if;
  import gdn_pkg::*;

  logic    valid;
  logic    ready;
  gdn_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/gdn_out_if.sv
// result output channel: valid/ready plus one normalized report
// depends on gdn_pkg
`timescale 1ns / 1ps

interface gdn_out_if;
  import gdn_pkg::*;

  logic     valid;
  logic     ready;
  gdn_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/gdn_cfg_if.sv
// register write channel: valid/ready, register index and write data
// depends on gdn_pkg
`timescale 1ns / 1ps

interface gdn_cfg_if;
  import gdn_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/gdn_lane.sv
// one axis lane: magnitude, dead-zone offset, Q15 scale and a pipelined
// restoring divider, one quotient bit per stage; depends on gdn_pkg
`timescale 1ns / 1ps

module gdn_lane (
  input  logic                                 clk_i,
  input  logic [gdn_pkg::LAST_STAGE:1]         en_i,
  input  logic                                 signed_i,
  input  logic [15:0]                          raw_i,
  input  gdn_pkg::gdn_dz_t                     cfg_i,
  output logic [15:0]                          res_o
);
  import gdn_pkg::*;

  logic [15:0] mag_d, mag_q;
  logic        neg_q [1:DIV_LAST];
  logic [16:0] diff;
  logic        dead;
  logic [14:0] n_d, n_q;
  logic [29:0] num_q;
  logic [14:0] rem_q [DIV_FIRST:DIV_LAST];
  logic [14:0] acc_q [DIV_FIRST:DIV_LAST];
  logic [15:0] res_q;

  // stage 1: magnitude and sign
  assign mag_d = (signed_i && raw_i[15]) ? 16'(~raw_i + 16'd1) : raw_i;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mag_q    <= mag_d;
      neg_q[1] <= signed_i & raw_i[15];
    end
  end

  // stage 2: distance past the dead zone, capped at the divisor
  assign diff = {1'b0, mag_q} - {2'b00, cfg_i.dz};
  assign dead = (mag_q <= {1'b0, cfg_i.dz});
  always_comb begin
    if (dead) begin
      n_d = '0;
    end else if (diff[15:0] > {1'b0, cfg_i.den}) begin
      n_d = cfg_i.den;
    end else begin
      n_d = diff[14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      n_q <= n_d;
    end
  end

  // stage 3: numerator n * 32767 as (n << 15) - n
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      num_q <= {n_q, 15'd0} - {15'd0, n_q};
    end
  end

  // sign bit rides along to the final stage
  for (genvar k = 2; k <= DIV_LAST; k++) begin : g_neg
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // divider steps: remainder stays below the divisor, quotient shifts in
  for (genvar k = DIV_FIRST; k <= DIV_LAST; k++) begin : g_div
    logic [14:0] rem_in, acc_in;
    logic [15:0] trial;
    logic        ge;

    if (k == DIV_FIRST) begin : g_head
      assign rem_in = num_q[29:15];
      assign acc_in = num_q[14:0];
    end else begin : g_body
      assign rem_in = rem_q[k-1];
      assign acc_in = acc_q[k-1];
    end

    assign trial = {rem_in, acc_in[14]};
    assign ge    = (trial >= {1'b0, cfg_i.den});

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k] <= ge ? 15'(trial - {1'b0, cfg_i.den}) : trial[14:0];
        acc_q[k] <= {acc_in[13:0], ge};
      end
    end
  end

  // final stage: restore the sign, rounding toward zero
  always_ff @(posedge clk_i) begin
    if (en_i[LAST_STAGE]) begin
      res_q <= neg_q[DIV_LAST] ? 16'(~{1'b0, acc_q[DIV_LAST]} + 16'd1)
                               : {1'b0, acc_q[DIV_LAST]};
    end
  end

  assign res_o = res_q;

endmodule

### rtl/gamepad_deadzone_normalizer_unit.sv
// gamepad dead-zone normalizer top level: config registers, sideband pipeline,
// six axis lanes; depends on gdn_pkg, the channel interfaces, gdn_lane, macros
//
//   channel | dir | carries                                   | accepted when
//   in_i    | in  | one controller report                     | valid & ready
//   out_o   | out | one normalized report                     | valid & ready
//   cfg_i   | in  | dead-zone register index and value        | valid & ready
//
// one report accepted per cycle sustained while the output beat is taken
// the 15-step restoring divider produces one quotient bit per stage
// reset clears all stage valid bits and loads the default dead zones
// a stage advances whenever it or any later stage is empty or the output beat
// is taken, so bubbles close up and input keeps flowing while a result waits
`timescale 1ns / 1ps
`include "gamepad_deadzone_normalizer_unit_macros.svh"

module gamepad_deadzone_normalizer_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  gdn_in_if.sink    in_i,
  gdn_out_if.source out_o,
  gdn_cfg_if.sink   cfg_i
);
  import gdn_pkg::*;

  gdn_dz_t     left_cfg_q, right_cfg_q, trig_cfg_q;
  gdn_dz_t     trig_cfg_ext;
  logic [14:0] stick_dz_d;
  logic [7:0]  trig_dz_d;

  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] en;
  gdn_sb_t               sb_q [0:LAST_STAGE];
  gdn_in_t               s0_q;
  logic                  live_in;

  logic [15:0] lx_res, ly_res, rx_res, ry_res, lt_res, rt_res;
  logic        last_zero, stick_ok, trig_ok;

  // dead-zone registers, stored clamped with their divisor
  assign cfg_i.ready = 1'b1;
  assign stick_dz_d  = stick_dz_clamp(cfg_i.data);
  assign trig_dz_d   = trig_dz_clamp(cfg_i.data[7:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cfg_q  <= '{dz: LEFT_DZ_RST, den: STICK_FULL - LEFT_DZ_RST};
      right_cfg_q <= '{dz: RIGHT_DZ_RST, den: STICK_FULL - RIGHT_DZ_RST};
      trig_cfg_q  <= '{dz: {7'd0, TRIG_DZ_RST}, den: {7'd0, TRIG_FULL - TRIG_DZ_RST}};
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LEFT_STICK: begin
          left_cfg_q <= '{dz: stick_dz_d, den: STICK_FULL - stick_dz_d};
        end
        CFG_RIGHT_STICK: begin
          right_cfg_q <= '{dz: stick_dz_d, den: STICK_FULL - stick_dz_d};
        end
        CFG_TRIGGER: begin
          trig_cfg_q <= '{dz: {7'd0, trig_dz_d}, den: {7'd0, TRIG_FULL - trig_dz_d}};
        end
        default: begin
        end
      endcase
    end
  end

  assign trig_cfg_ext = trig_cfg_q;

  // stage enables: move when this or a later stage has room
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
    assign en[k] = out_o.ready | ~(&v_q[LAST_STAGE:k]);
  end

  assign in_i.ready = en[0];

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // input register; a disconnected pad enters with all values zeroed
  assign live_in = in_i.data.present && (32'(in_i.data.pad_number) < PAD_COUNT);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_q       <= live_in ? in_i.data : '0;
      sb_q[0]    <= '{pad: in_i.data.pad_number, live: live_in,
                      buttons: live_in ? in_i.data.button_bits : 16'd0};
    end
  end

  // sideband rides along with the lanes
  for (genvar k = 1; k <= LAST_STAGE; k++) begin : g_sb
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  // six axis lanes
  gdn_lane u_lane_lx (
    .clk_i (clk_i), .en_i (en[LAST_STAGE:1]), .signed_i (1'b1),
    .raw_i (s0_q.left_x_raw), .cfg_i (left_cfg_q), .res_o (lx_res)
  );
  gdn_lane u_lane_ly (
    .clk_i (clk_i), .en_i (en[LAST_STAGE:1]), .signed_i (1'b1),
    .raw_i (s0_q.left_y_raw), .cfg_i (left_cfg_q), .res_o (ly_res)
  );
  gdn_lane u_lane_rx (
    .clk_i (clk_i), .en_i (en[LAST_STAGE:1]), .signed_i (1'b1),
    .raw_i (s0_q.right_x_raw), .cfg_i (right_cfg_q), .res_o (rx_res)
  );
  gdn_lane u_lane_ry (
    .clk_i (clk_i), .en_i (en[LAST_STAGE:1]), .signed_i (1'b1),
    .raw_i (s0_q.right_y_raw), .cfg_i (right_cfg_q), .res_o (ry_res)
  );
  gdn_lane u_lane_lt (
    .clk_i (clk_i), .en_i (en[LAST_STAGE:1]), .signed_i (1'b0),
    .raw_i ({8'd0, s0_q.left_trigger_raw}), .cfg_i (trig_cfg_ext), .res_o (lt_res)
  );
  gdn_lane u_lane_rt (
    .clk_i (clk_i), .en_i (en[LAST_STAGE:1]), .signed_i (1'b0),
    .raw_i ({8'd0, s0_q.right_trigger_raw}), .cfg_i (trig_cfg_ext), .res_o (rt_res)
  );

  // output beat straight from the last stage registers
  assign out_o.valid = v_q[LAST_STAGE];
  always_comb begin
    out_o.data                    = '0;
    out_o.data.pad_out            = sb_q[LAST_STAGE].pad;
    out_o.data.present_out        = sb_q[LAST_STAGE].live;
    out_o.data.left_x_norm        = lx_res;
    out_o.data.left_y_norm        = ly_res;
    out_o.data.right_x_norm       = rx_res;
    out_o.data.right_y_norm       = ry_res;
    out_o.data.left_trigger_norm  = lt_res[14:0];
    out_o.data.right_trigger_norm = rt_res[14:0];
    out_o.data.buttons_out        = sb_q[LAST_STAGE].buttons;
  end

  // summary terms for the checks below
  assign last_zero = ~|{lx_res, ly_res, rx_res, ry_res, lt_res, rt_res,
                        sb_q[LAST_STAGE].buttons};
  assign stick_ok  = (lx_res != 16'h8000) && (ly_res != 16'h8000) &&
                     (rx_res != 16'h8000) && (ry_res != 16'h8000);
  assign trig_ok   = ~lt_res[15] & ~rt_res[15];

  // checks on the datapath and pipeline control
  `GDN_ASSERT_NOW(a_dead_pad_zero, out_o.valid && !sb_q[LAST_STAGE].live, last_zero, "disconnected pad gave a nonzero value")
  `GDN_ASSERT_NOW(a_stick_range, out_o.valid, stick_ok, "stick output below -32767")
  `GDN_ASSERT_NOW(a_trig_range, out_o.valid, trig_ok, "trigger output out of Q15 range")
  `GDN_ASSERT_NEXT(a_beat_enters, in_i.valid && in_i.ready, v_q[0], "accepted beat not held")

endmodule
